@@ rtl/aou_pkg.sv @@
// Package for the 6502 operand address unit: request/result payload types,
// addressing mode codes, argument kinds, phase codes and cycle counts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aou_pkg;

  // request kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // addressing modes
  localparam logic [3:0] AM_ACCUM        = 4'd0;
  localparam logic [3:0] AM_ABSOLUTE     = 4'd1;
  localparam logic [3:0] AM_ABSOLUTE_X   = 4'd2;
  localparam logic [3:0] AM_ABSOLUTE_Y   = 4'd3;
  localparam logic [3:0] AM_IMMEDIATE    = 4'd4;
  localparam logic [3:0] AM_IMPLIED      = 4'd5;
  localparam logic [3:0] AM_INDIRECT     = 4'd6;
  localparam logic [3:0] AM_PRE_INDEXED  = 4'd7;
  localparam logic [3:0] AM_POST_INDEXED = 4'd8;
  localparam logic [3:0] AM_RELATIVE     = 4'd9;
  localparam logic [3:0] AM_ZPAGE        = 4'd10;
  localparam logic [3:0] AM_ZPAGE_X      = 4'd11;
  localparam logic [3:0] AM_ZPAGE_Y      = 4'd12;

  // argument kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_ADDR = 2'd2;

  // indirect sequence phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // pending indirect mode
  localparam logic [1:0] PM_IND = 2'd0;
  localparam logic [1:0] PM_INX = 2'd1;
  localparam logic [1:0] PM_INY = 2'd2;

  // extra cycles per mode
  localparam logic [2:0] CYC_NONE = 3'd0;
  localparam logic [2:0] CYC_IMM  = 3'd1;
  localparam logic [2:0] CYC_REL  = 3'd1;
  localparam logic [2:0] CYC_ZP   = 3'd2;
  localparam logic [2:0] CYC_ABS  = 3'd3;
  localparam logic [2:0] CYC_INXY = 3'd5;
  localparam logic [2:0] CYC_IND  = 3'd7;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  mode;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_hi;
    logic [7:0]  reg_a;
    logic [7:0]  reg_x;
    logic [7:0]  reg_y;
    logic [15:0] next_pc;
    logic [7:0]  read_data;
  } req_t;

  typedef struct packed {
    logic        is_final;
    logic [15:0] read_addr;
    logic [1:0]  arg_kind;
    logic [7:0]  arg_lo;
    logic [7:0]  arg_hi;
    logic [2:0]  extra_cycles;
    logic [1:0]  bytes_used;
    logic        error;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/aou_stream_if.sv @@
// Valid/ready stream interface carrying one payload of a chosen type.
// Used with aou_pkg::req_t and aou_pkg::rsp_t.
`timescale 1ns / 1ps
`default_nettype none

interface aou_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/cpu6502_operand_address_unit.sv @@
// 6502 operand address unit: decodes addressing modes, drives the indirect
// pointer read sequence. Depends on aou_pkg and aou_stream_if.
//
//  channel | dir | payload        | role
//  --------+-----+----------------+---------------------------------------
//  req     | in  | aou_pkg::req_t | start decode or returned bus read data
//  rsp     | out | aou_pkg::rsp_t | bus read request or final argument
//
// Each request yields one result in the cycle after it is accepted; a
// request can be accepted every cycle unless a result waits with rsp.ready
// low. Decode and address sums sit between the request port and the result
// register. rst (synchronous) returns the sequencer to idle and empties the
// result register. While a result waits there, req.ready follows rsp.ready.
`timescale 1ns / 1ps
`default_nettype none

module cpu6502_operand_address_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  aou_stream_if.sink   req,
  aou_stream_if.source rsp
);

  logic [1:0]  phase, phase_next;
  logic [1:0]  pending_mode, pending_mode_next;
  logic [15:0] pointer_addr, pointer_addr_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  saved_index, saved_index_next;

  logic          out_valid;
  aou_pkg::rsp_t out_data;
  aou_pkg::rsp_t res;
  aou_pkg::req_t r;

  logic        accept;
  logic        busy;
  logic [15:0] abs_addr;
  logic [15:0] ind_addr;
  logic [7:0]  zpx_addr;

  assign r        = req.payload;
  assign req.ready = !out_valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign busy     = (phase == aou_pkg::PH_FIRST) || (phase == aou_pkg::PH_SECOND);
  assign abs_addr = {r.operand_hi, r.operand_lo};
  assign ind_addr = {r.read_data, first_byte};
  assign zpx_addr = r.operand_lo + r.reg_x;

  always_comb begin
    res               = '0;
    res.is_final      = 1'b1;
    phase_next        = phase;
    pending_mode_next = pending_mode;
    pointer_addr_next = pointer_addr;
    first_byte_next   = first_byte;
    saved_index_next  = saved_index;
    if (r.opcode == aou_pkg::OP_START) begin
      if (busy) begin
        res.error = 1'b1;
      end else begin
        unique case (r.mode)
          aou_pkg::AM_ACCUM: begin
            res.arg_kind = aou_pkg::KIND_BYTE;
            res.arg_lo   = r.reg_a;
          end
          aou_pkg::AM_ABSOLUTE, aou_pkg::AM_ABSOLUTE_X, aou_pkg::AM_ABSOLUTE_Y: begin
            res.arg_kind     = aou_pkg::KIND_ADDR;
            res.extra_cycles = aou_pkg::CYC_ABS;
            res.bytes_used   = 2'd2;
            if (r.mode == aou_pkg::AM_ABSOLUTE_X) begin
              {res.arg_hi, res.arg_lo} = abs_addr + {8'd0, r.reg_x};
            end else if (r.mode == aou_pkg::AM_ABSOLUTE_Y) begin
              {res.arg_hi, res.arg_lo} = abs_addr + {8'd0, r.reg_y};
            end else begin
              {res.arg_hi, res.arg_lo} = abs_addr;
            end
          end
          aou_pkg::AM_IMMEDIATE: begin
            res.arg_kind     = aou_pkg::KIND_BYTE;
            res.arg_lo       = r.operand_lo;
            res.extra_cycles = aou_pkg::CYC_IMM;
            res.bytes_used   = 2'd1;
          end
          aou_pkg::AM_IMPLIED: begin
            res.arg_kind = aou_pkg::KIND_NONE;
          end
          aou_pkg::AM_INDIRECT, aou_pkg::AM_PRE_INDEXED, aou_pkg::AM_POST_INDEXED: begin
            // issue the first pointer read and arm the sequencer
            res.is_final     = 1'b0;
            saved_index_next = r.reg_y;
            first_byte_next  = 8'd0;
            phase_next       = aou_pkg::PH_FIRST;
            if (r.mode == aou_pkg::AM_INDIRECT) begin
              res.read_addr     = abs_addr;
              pending_mode_next = aou_pkg::PM_IND;
            end else if (r.mode == aou_pkg::AM_PRE_INDEXED) begin
              res.read_addr     = {8'd0, zpx_addr};
              pending_mode_next = aou_pkg::PM_INX;
            end else begin
              res.read_addr     = {8'd0, r.operand_lo};
              pending_mode_next = aou_pkg::PM_INY;
            end
            pointer_addr_next = res.read_addr;
          end
          aou_pkg::AM_RELATIVE: begin
            res.arg_kind     = aou_pkg::KIND_ADDR;
            {res.arg_hi, res.arg_lo} = r.next_pc + {{8{r.operand_lo[7]}}, r.operand_lo};
            res.extra_cycles = aou_pkg::CYC_REL;
            res.bytes_used   = 2'd1;
          end
          aou_pkg::AM_ZPAGE, aou_pkg::AM_ZPAGE_X, aou_pkg::AM_ZPAGE_Y: begin
            res.arg_kind     = aou_pkg::KIND_ADDR;
            res.extra_cycles = aou_pkg::CYC_ZP;
            res.bytes_used   = 2'd1;
            if (r.mode == aou_pkg::AM_ZPAGE_X) begin
              res.arg_lo = zpx_addr;
            end else if (r.mode == aou_pkg::AM_ZPAGE_Y) begin
              res.arg_lo = r.operand_lo + r.reg_y;
            end else begin
              res.arg_lo = r.operand_lo;
            end
          end
          default: begin
            res.error = 1'b1;
          end
        endcase
      end
    end else begin
      priority if (!busy) begin
        res.error = 1'b1;
      end else if (phase == aou_pkg::PH_FIRST) begin
        // second pointer byte: plain 16-bit increment, no page wrap
        res.is_final    = 1'b0;
        res.read_addr   = pointer_addr + 16'd1;
        first_byte_next = r.read_data;
        phase_next      = aou_pkg::PH_SECOND;
      end else begin
        phase_next   = aou_pkg::PH_IDLE;
        res.arg_kind = aou_pkg::KIND_ADDR;
        unique case (pending_mode)
          aou_pkg::PM_IND: begin
            {res.arg_hi, res.arg_lo} = ind_addr;
            res.extra_cycles = aou_pkg::CYC_IND;
            res.bytes_used   = 2'd2;
          end
          aou_pkg::PM_INX: begin
            {res.arg_hi, res.arg_lo} = ind_addr;
            res.extra_cycles = aou_pkg::CYC_INXY;
            res.bytes_used   = 2'd1;
          end
          default: begin
            {res.arg_hi, res.arg_lo} = ind_addr + {8'd0, saved_index};
            res.extra_cycles = aou_pkg::CYC_INXY;
            res.bytes_used   = 2'd1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= aou_pkg::PH_IDLE;
      pending_mode <= aou_pkg::PM_IND;
      pointer_addr <= 16'd0;
      first_byte   <= 8'd0;
      saved_index  <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        pending_mode <= pending_mode_next;
        pointer_addr <= pointer_addr_next;
        first_byte   <= first_byte_next;
        saved_index  <= saved_index_next;
        out_valid    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("sequencer phase left its legal range");

  a_read_req_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.is_final) |->
      (phase == aou_pkg::PH_FIRST || phase == aou_pkg::PH_SECOND))
    else $error("read request shown while sequencer idle");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |->
      (out_data.is_final && out_data.arg_kind == aou_pkg::KIND_NONE &&
       out_data.read_addr == 16'd0 && out_data.extra_cycles == 3'd0 &&
       out_data.bytes_used == 2'd0))
    else $error("error result carries nonzero fields");

  a_start_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && r.opcode == aou_pkg::OP_START && busy) |=>
      (phase == $past(phase) && pointer_addr == $past(pointer_addr)))
    else $error("start while pending changed sequencer state");

  a_final_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_final) |-> out_data.read_addr == 16'd0)
    else $error("final result carries a read address");
`endif

endmodule

`default_nettype wire

@@ tb/tb_cpu6502_operand_address_unit.sv @@
// Self-checking bench for cpu6502_operand_address_unit: directed and random
// addressing-mode requests, checked against an in-bench model of the decoder.
// Depends on aou_pkg, aou_stream_if and the unit itself.
`timescale 1ns / 1ps

module tb_cpu6502_operand_address_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 80;
  localparam int CALM_LO     = 320;
  localparam int CALM_HI     = 470;
  localparam int GAP_PCT     = 14;
  localparam int N_RANDOM    = 450;

  logic clk;
  logic rst;

  aou_stream_if #(.payload_t(aou_pkg::req_t)) req_if ();
  aou_stream_if #(.payload_t(aou_pkg::rsp_t)) rsp_if ();

  cpu6502_operand_address_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  aou_pkg::req_t stim_q[$];
  aou_pkg::rsp_t operand_results[$];
  int   cyc_cnt   = 0;
  int   hold_left = 0;
  int   fail_cnt  = 0;

  // model state of the indirect pointer sequence
  logic [1:0]  seq_phase  = aou_pkg::PH_IDLE;
  logic [1:0]  seq_mode   = aou_pkg::PM_IND;
  logic [15:0] seq_ptr    = '0;
  logic [7:0]  seq_lo     = '0;
  logic [7:0]  seq_index  = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_gap();
    return (cyc_cnt < CALM_LO || cyc_cnt >= CALM_HI) && ($urandom_range(99) < GAP_PCT);
  endfunction

  function automatic aou_pkg::req_t make_req(logic op, logic [3:0] m, logic [15:0] oper);
    aou_pkg::req_t r;
    r.opcode     = op;
    r.mode       = m;
    r.operand_lo = oper[7:0];
    r.operand_hi = oper[15:8];
    r.reg_a      = 8'($urandom_range(255));
    r.reg_x      = 8'($urandom_range(255));
    r.reg_y      = 8'($urandom_range(255));
    r.next_pc    = 16'($urandom_range(65535));
    r.read_data  = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic aou_pkg::rsp_t addr_result(logic [15:0] ea, logic [2:0] cyc,
                                                logic [1:0] used);
    aou_pkg::rsp_t res;
    res              = '0;
    res.is_final     = 1'b1;
    res.arg_kind     = aou_pkg::KIND_ADDR;
    res.arg_lo       = ea[7:0];
    res.arg_hi       = ea[15:8];
    res.extra_cycles = cyc;
    res.bytes_used   = used;
    return res;
  endfunction

  // Work out the result of one accepted request and advance the model state.
  task automatic decode_step(input aou_pkg::req_t r);
    aou_pkg::rsp_t res;
    logic          busy;
    logic [15:0]   oper;
    logic [15:0]   ea;
    logic [7:0]    zsum;
    res          = '0;
    res.is_final = 1'b1;
    busy         = (seq_phase == aou_pkg::PH_FIRST) || (seq_phase == aou_pkg::PH_SECOND);
    oper         = {r.operand_hi, r.operand_lo};
    if (r.opcode == aou_pkg::OP_START) begin
      if (busy) begin
        res.error = 1'b1;
      end else begin
        case (r.mode)
          aou_pkg::AM_ACCUM: begin
            res.arg_kind = aou_pkg::KIND_BYTE;
            res.arg_lo   = r.reg_a;
          end
          aou_pkg::AM_ABSOLUTE: res = addr_result(oper, aou_pkg::CYC_ABS, 2'd2);
          aou_pkg::AM_ABSOLUTE_X:
            res = addr_result(oper + {8'h00, r.reg_x}, aou_pkg::CYC_ABS, 2'd2);
          aou_pkg::AM_ABSOLUTE_Y:
            res = addr_result(oper + {8'h00, r.reg_y}, aou_pkg::CYC_ABS, 2'd2);
          aou_pkg::AM_IMMEDIATE: begin
            res.arg_kind     = aou_pkg::KIND_BYTE;
            res.arg_lo       = r.operand_lo;
            res.extra_cycles = aou_pkg::CYC_IMM;
            res.bytes_used   = 2'd1;
          end
          aou_pkg::AM_IMPLIED: ;
          aou_pkg::AM_INDIRECT, aou_pkg::AM_PRE_INDEXED, aou_pkg::AM_POST_INDEXED: begin
            zsum = r.operand_lo + r.reg_x;
            if (r.mode == aou_pkg::AM_INDIRECT) begin
              seq_ptr  = oper;
              seq_mode = aou_pkg::PM_IND;
            end else if (r.mode == aou_pkg::AM_PRE_INDEXED) begin
              seq_ptr  = {8'h00, zsum};
              seq_mode = aou_pkg::PM_INX;
            end else begin
              seq_ptr  = {8'h00, r.operand_lo};
              seq_mode = aou_pkg::PM_INY;
            end
            seq_index     = r.reg_y;
            seq_lo        = '0;
            seq_phase     = aou_pkg::PH_FIRST;
            res.is_final  = 1'b0;
            res.read_addr = seq_ptr;
          end
          aou_pkg::AM_RELATIVE: begin
            ea  = r.next_pc + {{8{r.operand_lo[7]}}, r.operand_lo};
            res = addr_result(ea, aou_pkg::CYC_REL, 2'd1);
          end
          aou_pkg::AM_ZPAGE:
            res = addr_result({8'h00, r.operand_lo}, aou_pkg::CYC_ZP, 2'd1);
          aou_pkg::AM_ZPAGE_X: begin
            zsum = r.operand_lo + r.reg_x;
            res  = addr_result({8'h00, zsum}, aou_pkg::CYC_ZP, 2'd1);
          end
          aou_pkg::AM_ZPAGE_Y: begin
            zsum = r.operand_lo + r.reg_y;
            res  = addr_result({8'h00, zsum}, aou_pkg::CYC_ZP, 2'd1);
          end
          default: res.error = 1'b1;
        endcase
      end
    end else if (!busy) begin
      res.error = 1'b1;
    end else if (seq_phase == aou_pkg::PH_FIRST) begin
      seq_lo        = r.read_data;
      seq_phase     = aou_pkg::PH_SECOND;
      res.is_final  = 1'b0;
      res.read_addr = seq_ptr + 16'd1;
    end else begin
      ea        = {r.read_data, seq_lo};
      seq_phase = aou_pkg::PH_IDLE;
      case (seq_mode)
        aou_pkg::PM_IND: res = addr_result(ea, aou_pkg::CYC_IND, 2'd2);
        aou_pkg::PM_INX: res = addr_result(ea, aou_pkg::CYC_INXY, 2'd1);
        default: res = addr_result(ea + {8'h00, seq_index}, aou_pkg::CYC_INXY, 2'd1);
      endcase
    end
    operand_results.push_back(res);
  endtask

  // Request driver: hold the payload until accepted, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (stim_q.size() != 0 && !take_gap()) begin
        req_if.valid   <= 1'b1;
        req_if.payload <= stim_q.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (hold_left == 0) && !take_gap();
    end
  end

  // Long result back-pressure so the unit fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cyc_cnt == HOLD_AT) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("[cpu6502_operand_address_unit] ERROR");
      $finish;
    end
  end

  // Result monitor: check against the oldest prediction, then predict new requests.
  always @(posedge clk) begin
    aou_pkg::rsp_t exp_r;
    aou_pkg::rsp_t got;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        if (operand_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result at cycle %0d: %p", cyc_cnt, got);
        end else begin
          exp_r = operand_results.pop_front();
          if (got.is_final !== exp_r.is_final || got.read_addr !== exp_r.read_addr ||
              got.arg_kind !== exp_r.arg_kind || got.arg_lo !== exp_r.arg_lo ||
              got.arg_hi !== exp_r.arg_hi || got.extra_cycles !== exp_r.extra_cycles ||
              got.bytes_used !== exp_r.bytes_used || got.error !== exp_r.error) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch at cycle %0d: expected %p, got %p", cyc_cnt, exp_r, got);
          end
        end
      end
      if (req_if.valid && req_if.ready)
        decode_step(req_if.payload);
    end
  end

  initial begin
    aou_pkg::req_t r;
    int   roll;
    int   k;
    rst = 1'b1;

    // directed: field extremes, every mode, wraps and the error cases
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ACCUM, 16'h0000); r.reg_a = 8'hFF;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ABSOLUTE, 16'hFFFF); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ABSOLUTE_X, 16'hFFFF); r.reg_x = 8'h01;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ABSOLUTE_Y, 16'hFF80); r.reg_y = 8'hFF;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_IMMEDIATE, 16'h00FF); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_IMPLIED, 16'h0000); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_RELATIVE, 16'h0080); r.next_pc = 16'h0010;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_RELATIVE, 16'h007F); r.next_pc = 16'hFFF0;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ZPAGE, 16'h00FF); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ZPAGE_X, 16'h00F0); r.reg_x = 8'h20;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ZPAGE_Y, 16'h00FF); r.reg_y = 8'hFF;
    stim_q.push_back(r);
    // indirect pointer at a page end reads across the page
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_INDIRECT, 16'h12FF); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_ABSOLUTE, 16'h1234); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_READ, aou_pkg::AM_ACCUM, 16'h0000); r.read_data = 8'h34;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_READ, aou_pkg::AM_ACCUM, 16'h0000); r.read_data = 8'h12;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_PRE_INDEXED, 16'h00FE); r.reg_x = 8'h01;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_READ, aou_pkg::AM_ACCUM, 16'h0000); r.read_data = 8'h00;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_READ, aou_pkg::AM_ACCUM, 16'h0000); r.read_data = 8'hFF;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, aou_pkg::AM_POST_INDEXED, 16'h00FF); r.reg_y = 8'h01;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_READ, aou_pkg::AM_ACCUM, 16'h0000); r.read_data = 8'hFF;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_READ, aou_pkg::AM_ACCUM, 16'h0000); r.read_data = 8'hFF;
    stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, 4'd13, 16'h0000); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_START, 4'd15, 16'hFFFF); stim_q.push_back(r);
    r = make_req(aou_pkg::OP_READ, aou_pkg::AM_ZPAGE_Y, 16'h0000); stim_q.push_back(r);

    // random: complete indirect sequences, plus direct modes and noise
    while (stim_q.size() < N_RANDOM + 24) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        stim_q.push_back(make_req(aou_pkg::OP_START, 4'($urandom_range(12)),
                                  16'($urandom_range(65535))));
      end else if (roll < 78) begin
        stim_q.push_back(make_req(aou_pkg::OP_START,
                                  4'(aou_pkg::AM_INDIRECT + $urandom_range(2)),
                                  16'($urandom_range(65535))));
        for (k = 0; k < 2; k++) begin
          if ($urandom_range(9) == 0)
            stim_q.push_back(make_req(aou_pkg::OP_START, 4'($urandom_range(15)),
                                      16'($urandom_range(65535))));
          stim_q.push_back(make_req(aou_pkg::OP_READ, 4'($urandom_range(15)),
                                    16'($urandom_range(65535))));
        end
      end else if (roll < 88) begin
        stim_q.push_back(make_req(aou_pkg::OP_START, 4'(13 + $urandom_range(2)),
                                  16'($urandom_range(65535))));
      end else begin
        stim_q.push_back(make_req(aou_pkg::OP_READ, 4'($urandom_range(15)),
                                  16'($urandom_range(65535))));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || req_if.valid) @(posedge clk);
    while (operand_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("[cpu6502_operand_address_unit] OK");
    end else begin
      $display("[cpu6502_operand_address_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ cpu6502_operand_address_unit.f @@
rtl/aou_pkg.sv
rtl/aou_stream_if.sv
rtl/cpu6502_operand_address_unit.sv
tb/tb_cpu6502_operand_address_unit.sv
